// File: hdl/fcss_pkg.sv
package fcss_pkg;

  localparam int MAX_NODES = 4096;
  localparam int MAX_SLOTS = 32768;

  typedef enum logic [1:0] {
    REQ_NODE     = 2'd0,
    REQ_NEIGHBOR = 2'd1,
    REQ_RUN      = 2'd2,
    REQ_NOP      = 2'd3
  } req_t;

  localparam logic [0:0] REG_NODE_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_POP,
    ST_ROW,
    ST_NBR_RD,
    ST_NBR_CHK,
    ST_NBR_DONE,
    ST_COMP_END,
    ST_DIV,
    ST_FRAC_WAIT,
    ST_AVG,
    ST_AVG_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [12:0] top_size;
    logic [16:0] largest_fraction;
    logic [12:0] cluster_count;
    logic [20:0] other_average;
  } result_t;

endpackage

// File: hdl/fcss_div.sv
// restoring divider, one quotient bit per cycle
module fcss_div #(
  parameter int NW = 29,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quot
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;

  assign trial = {rem_r[DW-1:0], q_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
      q_r    <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

// File: hdl/filtered_component_size_stats.sv
// load transactions are accepted one per cycle while the walk is idle
// a run transaction first clears the visited map over node_count entries, then scans
// each node, walks each component, each visited node and each neighbor entry (out of
// range entries skip the row check), then runs up to two 29-step divisions and the result register
// a waiting result blocks only a run
// reset: synchronous active low, clears control state and sets node_count to 1
module filtered_component_size_stats (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[1:0], node_id[13:2], is_private[14], first_slot[29:15], degree[41:30],
  // slot[56:42], neighbor[68:57], zero fill to 72
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // top_size[12:0], largest_fraction[29:13], cluster_count[42:30],
  // other_average[63:43]
  output logic [63:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fcss_pkg::*;

  localparam int NB = $clog2(MAX_NODES);
  localparam int SB = $clog2(MAX_SLOTS);

  // input field unpack
  logic [1:0]  f_req;
  logic [11:0] f_node, f_degree, f_nbr;
  logic        f_priv;
  logic [14:0] f_first, f_slot;
  assign f_req   = in_tdata[1:0];
  assign f_node  = in_tdata[13:2];
  assign f_priv  = in_tdata[14];
  assign f_first = in_tdata[29:15];
  assign f_degree= in_tdata[41:30];
  assign f_slot  = in_tdata[56:42];
  assign f_nbr   = in_tdata[68:57];

  // config register
  logic [12:0] node_count_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == 2'b00) ? {19'd0, node_count_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= 13'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00)
      node_count_r <= cfg_pwdata[12:0];
  end

  // used node count saturates at MAX_NODES
  logic [16:0] n_used;
  assign n_used = ({4'd0, node_count_r} > 17'(MAX_NODES)) ? 17'(MAX_NODES)
                                                          : {4'd0, node_count_r};

  // memories
  logic [27:0] row_mem [MAX_NODES];   // private, start, length
  logic [11:0] nbr_mem [MAX_SLOTS];
  logic        vis_mem [MAX_NODES];
  logic [NB-1:0] q_mem [MAX_NODES];

  logic          row_we;
  logic [NB-1:0] row_wa, row_ra;
  logic [27:0]   row_wd, row_rd;
  logic          nbr_we;
  logic [SB-1:0] nbr_wa, nbr_ra;
  logic [11:0]   nbr_wd, nbr_rd;
  logic          vis_we, vis_wd, vis_rd;
  logic [NB-1:0] vis_wa, vis_ra;
  logic          q_we;
  logic [NB-1:0] q_wa, q_ra, q_rd, q_wd;

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    row_rd <= row_mem[row_ra];
  end
  always_ff @(posedge clk) begin
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
    nbr_rd <= nbr_mem[nbr_ra];
  end
  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd <= vis_mem[vis_ra];
  end
  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd <= q_mem[q_ra];
  end

  // search control
  state_t        state_r, state_nxt;
  logic [16:0]   idx_r, idx_nxt;        // clear index / scan node
  logic [16:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [SB:0]   slot_r, slot_nxt;
  logic [11:0]   left_r, left_nxt;
  logic [11:0]   w_r, w_nxt;
  logic [12:0]   cur_r, cur_nxt, best_r, best_nxt, total_r, total_nxt, tally_r, tally_nxt;
  logic          phase_r, phase_nxt;    // 0 row data pending, 1 walking neighbor slots
  logic [16:0]   frac_r, frac_nxt;
  logic [20:0]   avg_r, avg_nxt;
  result_t       res_r, res_nxt;
  logic          outv_r, outv_nxt;

  // divider
  logic        div_start, div_busy;
  logic [28:0] div_num, div_quot;
  logic [12:0] div_den;
  fcss_div #(.NW(29), .DW(13)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quot(div_quot)
  );

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  logic [SB:0] slot_sum;
  assign slot_sum = (SB+1)'(row_rd[26:12]) ;

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; head_nxt = head_r; tail_nxt = tail_r;
    slot_nxt = slot_r; left_nxt = left_r; w_nxt = w_r;
    cur_nxt = cur_r; best_nxt = best_r; total_nxt = total_r; tally_nxt = tally_r;
    phase_nxt = phase_r; frac_nxt = frac_r; avg_nxt = avg_r; res_nxt = res_r;
    outv_nxt = outv_r;
    row_we = 1'b0; row_wa = f_node[NB-1:0];
    row_wd = {f_priv, f_first, f_degree};
    row_ra = idx_r[NB-1:0];
    nbr_we = 1'b0; nbr_wa = f_slot[SB-1:0]; nbr_wd = f_nbr; nbr_ra = slot_r[SB-1:0];
    vis_we = 1'b0; vis_wa = idx_r[NB-1:0]; vis_wd = 1'b0; vis_ra = idx_r[NB-1:0];
    q_we = 1'b0; q_wa = tail_r[NB-1:0]; q_wd = w_r[NB-1:0]; q_ra = head_r[NB-1:0];
    div_start = 1'b0; div_num = '0; div_den = n_used[12:0];

    if (outv_r && out_tready) outv_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (f_req == REQ_NODE && 17'(f_node) < 17'(MAX_NODES)) row_we = 1'b1;
          if (f_req == REQ_NEIGHBOR && 21'(f_slot) < 21'(MAX_SLOTS)) nbr_we = 1'b1;
          if (f_req == REQ_RUN) begin
            idx_nxt = '0; best_nxt = '0; total_nxt = '0; tally_nxt = '0;
            state_nxt = (n_used == 17'd0) ? ST_DIV : ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        vis_we = 1'b1;
        if (idx_r + 17'd1 >= n_used) begin
          idx_nxt = '0; state_nxt = ST_SCAN;
        end else idx_nxt = idx_r + 17'd1;
      end
      ST_SCAN: begin
        // read row and visited of node idx
        if (idx_r >= n_used) state_nxt = ST_DIV;
        else state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (!row_rd[27] && !vis_rd) begin
          vis_we = 1'b1; vis_wd = 1'b1;
          q_we = 1'b1; q_wa = '0; q_wd = idx_r[NB-1:0];
          head_nxt = '0; tail_nxt = 17'd1; cur_nxt = '0;
          state_nxt = ST_POP;
        end else begin
          idx_nxt = idx_r + 17'd1; state_nxt = ST_SCAN;
        end
      end
      ST_POP: begin
        // queue read at head issued here
        if (head_r >= tail_r) state_nxt = ST_COMP_END;
        else state_nxt = ST_ROW;
      end
      ST_ROW: begin
        // q_rd valid: issue row read of popped node
        row_ra = q_rd;
        head_nxt = head_r + 17'd1;
        cur_nxt = cur_r + 13'd1;
        state_nxt = ST_NBR_DONE;
        phase_nxt = 1'b0;
      end
      ST_NBR_DONE: begin
        if (!phase_r) begin
          // row_rd valid
          slot_nxt = slot_sum;
          left_nxt = row_rd[11:0];
          phase_nxt = 1'b1;
          state_nxt = ST_NBR_DONE;
        end else if (left_r == 12'd0 || slot_r >= (SB+1)'(MAX_SLOTS)) begin
          // slots rise monotonically so once past the end all are skipped
          state_nxt = ST_POP;
        end else begin
          state_nxt = ST_NBR_RD;
        end
      end
      ST_NBR_RD: begin
        // nbr_rd valid: issue row and visited reads of w
        w_nxt = nbr_rd;
        row_ra = nbr_rd[NB-1:0];
        vis_ra = nbr_rd[NB-1:0];
        slot_nxt = slot_r + (SB+1)'(1);
        left_nxt = left_r - 12'd1;
        if (17'(nbr_rd) >= n_used) state_nxt = ST_NBR_DONE;
        else state_nxt = ST_NBR_CHK;
      end
      ST_NBR_CHK: begin
        if (!row_rd[27] && !vis_rd && tail_r < 17'(MAX_NODES)) begin
          vis_we = 1'b1; vis_wa = w_r[NB-1:0]; vis_wd = 1'b1;
          q_we = 1'b1;
          tail_nxt = tail_r + 17'd1;
        end
        state_nxt = ST_NBR_DONE;
      end
      ST_COMP_END: begin
        tally_nxt = tally_r + 13'd1;
        total_nxt = total_r + cur_r;
        if (cur_r > best_r) best_nxt = cur_r;
        idx_nxt = idx_r + 17'd1;
        state_nxt = ST_SCAN;
        phase_nxt = 1'b0;
      end
      ST_DIV: begin
        // no public component gives all zero fields
        if (tally_r == 13'd0) begin
          frac_nxt = '0; avg_nxt = '0; state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1; div_num = {best_r, 16'd0};
          state_nxt = ST_FRAC_WAIT;
        end
      end
      ST_FRAC_WAIT: begin
        if (!div_busy) begin
          frac_nxt = div_quot[16:0];
          avg_nxt = '0;
          // a single component has no other mean
          state_nxt = (tally_r > 13'd1) ? ST_AVG : ST_OUT;
        end
      end
      ST_AVG: begin
        div_start = 1'b1;
        div_num   = {8'd0, total_r - best_r, 8'd0};
        div_den   = tally_r - 13'd1;
        state_nxt = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (!div_busy) begin
          avg_nxt = div_quot[20:0]; state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait here while an earlier result is still unread
        if (!outv_r || out_tready) begin
          res_nxt.top_size         = best_r;
          res_nxt.largest_fraction = frac_r;
          res_nxt.cluster_count    = tally_r;
          res_nxt.other_average    = avg_r;
          outv_nxt = 1'b1; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      outv_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
    slot_r <= slot_nxt; left_r <= left_nxt; w_r <= w_nxt; cur_r <= cur_nxt;
    best_r <= best_nxt; total_r <= total_nxt; tally_r <= tally_nxt;
    frac_r <= frac_nxt; avg_r <= avg_nxt; res_r <= res_nxt;
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = {res_r.other_average, res_r.cluster_count,
                       res_r.largest_fraction, res_r.top_size};

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid);
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata));
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy);
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP |-> head_r <= tail_r);
`endif

endmodule
